@@ sv/frame_prefix_size_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// Frame prefix size parser assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef FRAME_PREFIX_SIZE_PARSER_TOP_DEFINES_SVH
`define FRAME_PREFIX_SIZE_PARSER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FPSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define FPSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/fpsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame prefix size parser package
// Item types, status and register codes, and prefix layout constants.
// ----------------------------------------------------------------------------
package fpsp_pkg;

  // Prefix layout
  localparam int PREFIX_BYTES         = 4;
  localparam int LONG_PREFIX_BYTES    = 8;
  localparam int FRAME_HEADER_BYTES   = 4;
  localparam int MESSAGE_HEADER_BYTES = 4;
  localparam int TRAILER_BYTES        = 1;

  localparam int POS_W   = 4;
  localparam int SLEN_W  = 16;
  localparam int LLEN_W  = 32;
  localparam int SIZE_W  = 33;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Minimum length after the prefix for each control flag value
  localparam logic [SIZE_W-1:0] MIN_FLAG_SET =
    SIZE_W'(FRAME_HEADER_BYTES + TRAILER_BYTES);
  localparam logic [SIZE_W-1:0] MIN_FLAG_CLR =
    SIZE_W'(FRAME_HEADER_BYTES + MESSAGE_HEADER_BYTES + TRAILER_BYTES);

  localparam logic [7:0] FLAG_MAX = 8'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] MAGIC_WORD_RST  = 16'hF00D;
  localparam logic [CFG_W-1:0] LONG_MARKER_RST = 16'h8000;
  localparam logic             LONG_BODY_RST   = 1'b0;

  typedef enum logic [2:0] {
    ST_MORE       = 3'd0,
    ST_READY      = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_FLAG   = 3'd3,
    ST_BAD_LENGTH = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_WORD     = 2'd0,
    CFG_LONG_MARKER    = 2'd1,
    CFG_LONG_BODY_ONLY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [SIZE_W-1:0] frame_size;
  } res_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] magic_word;
    logic [CFG_W-1:0] long_marker;
    logic             long_body_only;
  } cfg_t;

endpackage

@@ sv/fpsp_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame prefix size parser stream interface
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface fpsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/fpsp_pipe_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame prefix size parser pipeline stage
// One valid/ready register slice; takes a new item whenever it empties.
// ----------------------------------------------------------------------------
module fpsp_pipe_stage #(
  parameter int WIDTH = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

@@ sv/fpsp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame prefix size parser core
// Parse state and per-byte verdict logic; state advances on each item moved.
// ----------------------------------------------------------------------------
`include "frame_prefix_size_parser_top_defines.svh"

module fpsp_parser
  import fpsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output res_item_t res_o
);

  logic [POS_W-1:0]  pos_q, pos_d, pos;
  logic [SLEN_W-1:0] slen_q, slen_d, slen;
  logic [LLEN_W-1:0] llen_q, llen_d, llen;
  logic              verdict_q, verdict_d, verdict;

  logic              is_long;
  logic [POS_W-1:0]  flag_pos;
  logic [7:0]        b;
  logic [SIZE_W-1:0] min_len;
  logic [SIZE_W-1:0] short_sum;
  logic [SIZE_W-1:0] long_add;
  logic [SIZE_W-1:0] long_sum;
  logic              long_too_short;
  status_e           status;
  logic [SIZE_W-1:0] size;

  always_comb begin
    b       = item_i.data_byte;
    // A first byte restarts the parse from a clean state
    pos     = item_i.frame_start ? '0 : pos_q;
    slen    = item_i.frame_start ? '0 : slen_q;
    llen    = item_i.frame_start ? '0 : llen_q;
    verdict = item_i.frame_start ? 1'b0 : verdict_q;

    is_long  = (slen == cfg_i.long_marker);
    flag_pos = is_long ? POS_W'(LONG_PREFIX_BYTES) : POS_W'(PREFIX_BYTES);

    min_len   = b[0] ? MIN_FLAG_SET : MIN_FLAG_CLR;
    short_sum = SIZE_W'(PREFIX_BYTES) + SIZE_W'(slen);
    long_add  = cfg_i.long_body_only ? (SIZE_W'(LONG_PREFIX_BYTES) + min_len)
                                     : SIZE_W'(LONG_PREFIX_BYTES + TRAILER_BYTES);
    long_sum  = SIZE_W'(llen) + long_add;
    long_too_short = (SIZE_W'(llen) + SIZE_W'(TRAILER_BYTES)) < min_len;

    status    = ST_MORE;
    size      = '0;
    slen_d    = slen;
    llen_d    = llen;
    pos_d     = pos;
    verdict_d = verdict;

    if (!verdict) begin
      if (pos == POS_W'(0)) begin
        if (b != cfg_i.magic_word[7:0]) status = ST_BAD_MAGIC;
      end else if (pos == POS_W'(1)) begin
        if (b != cfg_i.magic_word[15:8]) status = ST_BAD_MAGIC;
      end else if (pos == POS_W'(2)) begin
        slen_d = {8'h00, b};
      end else if (pos == POS_W'(3)) begin
        slen_d = {b, slen[7:0]};
      end else if (pos == flag_pos) begin
        if (b > FLAG_MAX) begin
          status = ST_BAD_FLAG;
        end else if (!is_long) begin
          if (SIZE_W'(slen) < min_len) begin
            status = ST_BAD_LENGTH;
          end else begin
            status = ST_READY;
            size   = short_sum;
          end
        end else if (!cfg_i.long_body_only && long_too_short) begin
          status = ST_BAD_LENGTH;
        end else begin
          status = ST_READY;
          size   = long_sum;
        end
      end else if (is_long && pos >= POS_W'(PREFIX_BYTES)
                   && pos < POS_W'(LONG_PREFIX_BYTES)) begin
        // Long length, little-endian, lane picked by position
        case (pos[1:0])
          2'd0:    llen_d[7:0]   = b;
          2'd1:    llen_d[15:8]  = b;
          2'd2:    llen_d[23:16] = b;
          default: llen_d[31:24] = b;
        endcase
      end

      if (status != ST_MORE) begin
        verdict_d = 1'b1;
      end else if (pos != '1) begin
        pos_d = pos + POS_W'(1);
      end
    end

    res_o.status     = status;
    res_o.frame_size = size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      slen_q    <= '0;
      llen_q    <= '0;
      verdict_q <= 1'b0;
    end else if (fire_i) begin
      pos_q     <= pos_d;
      slen_q    <= slen_d;
      llen_q    <= llen_d;
      verdict_q <= verdict_d;
    end
  end

  `FPSP_ASSERT(a_verdict_latched, fire_i && res_o.status != ST_MORE |=> verdict_q, "verdict not latched")
  `FPSP_ASSERT(a_ignore_after_verdict, fire_i && verdict_q && !item_i.frame_start |-> res_o.status == ST_MORE && res_o.frame_size == '0, "byte after verdict not ignored")
  `FPSP_ASSERT(a_state_hold, !fire_i |=> $stable(pos_q) && $stable(verdict_q) && $stable(slen_q), "state moved without an item")
  `FPSP_ASSERT_ALWAYS(a_reset_clear, (!rst_ni ##1 !rst_ni) |-> !verdict_q && pos_q == '0, "state not cleared in reset")

endmodule

@@ sv/frame_prefix_size_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame prefix size parser
// Per-byte parse of a length-prefixed frame header into a size or an error.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one prefix byte per item plus frame_start, set on byte 0.
//   out_o returns one result item per input item: status (need more, size
//         ready, bad magic, bad control flag, bad length) and frame_size,
//         nonzero only when the size is ready.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write magic_word, long_marker and
//   long_body_only; write them only while no item is in flight.
// Path: an accepted item passes through the input register, then the result
//   register, before it can be taken from out_o.
// Throughput: one item per cycle while out_o is ready; the parse state updates
//   in the same cycle the item moves from the input into the result register.
// Reset: clears both stage valids and the parse state, loads the register
//   reset values; the first byte after reset parses as byte 0.
// Stall: a held out_o keeps its result; the input register still fills, and
//   in_i.ready drops only once both registers hold items.
// ----------------------------------------------------------------------------
module frame_prefix_size_parser_top
  import fpsp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fpsp_stream_if.sink          in_i,
  fpsp_stream_if.source        out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t      cfg_q;
  in_item_t  item_in;
  in_item_t  item_q;
  res_item_t res_d;
  res_item_t res_q;
  logic      item_valid_q;
  logic      res_ready;
  logic      fire;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word     <= MAGIC_WORD_RST;
      cfg_q.long_marker    <= LONG_MARKER_RST;
      cfg_q.long_body_only <= LONG_BODY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC_WORD:     cfg_q.magic_word     <= cfg_wdata_i;
        CFG_LONG_MARKER:    cfg_q.long_marker    <= cfg_wdata_i;
        CFG_LONG_BODY_ONLY: cfg_q.long_body_only <= cfg_wdata_i[0];
        default:            ;
      endcase
    end
  end

  assign item_in = in_i.data;

  // Input register: hold the incoming byte
  fpsp_pipe_stage #(
    .WIDTH ($bits(in_item_t))
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (item_in),
    .valid_o (item_valid_q),
    .ready_i (res_ready),
    .data_o  (item_q)
  );

  // Advance the parse state whenever the byte moves on to the result register
  assign fire = item_valid_q && res_ready;

  fpsp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register: hold the verdict until the sink takes it
  fpsp_pipe_stage #(
    .WIDTH ($bits(res_item_t))
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid_q),
    .ready_o (res_ready),
    .data_i  (res_d),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res_q)
  );

  assign out_o.data = res_q;

endmodule

@@ tb/frame_prefix_size_parser_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame prefix size parser testbench
// Streams frame prefixes byte by byte through the parser: a directed set of
// edge frames, then random well-formed, corrupted, truncated and noise frames
// under several register settings. A byte-level predictor tracks the parse
// state and every returned item is checked against the oldest prediction,
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module frame_prefix_size_parser_top_tb;
  import fpsp_pkg::*;

  typedef logic [7:0] byte_seq_t[$];

  // Random part size per register setting, and the long output stall
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER  = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  fpsp_stream_if #(.payload_t(in_item_t))  in_if ();
  fpsp_stream_if #(.payload_t(res_item_t)) out_if ();

  frame_prefix_size_parser_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Bytes waiting to be offered, and verdicts predicted for accepted bytes
  in_item_t  frame_bytes[$];
  res_item_t pending_verdicts[$];

  // Predictor copy of the register file and of the parse state
  cfg_t              parse_cfg;
  logic [POS_W-1:0]  pos;
  logic [SLEN_W-1:0] slen;
  logic [LLEN_W-1:0] llen;
  logic              judged;

  int  fault_cnt   = 0;
  int  items_taken = 0;
  int  stim_cnt    = 0;
  int  src_gap     = 0;
  int  sink_gap    = 0;
  bit  gaps_on     = 1'b1;
  logic hold_off;

  // --------------------------------------------------------------------------
  // Clock, and a hard stop well past the slowest legal run. About 1300 items,
  // each in the worst case waiting out the longest source gap and the longest
  // sink stall, plus the long stall and register writes, finish well inside
  // the timeout, which gives ample margin.
  // --------------------------------------------------------------------------
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, a few long ones; none while idling is switched off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void note_fault(string what);
    if (fault_cnt < 10) $display("%0t: %s", $time, what);
    fault_cnt++;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: advance the parse state by one byte and return the verdict.
  // Magic at bytes 0..1, short length at 2..3; a short length equal to the
  // long marker moves the control flag from byte 4 to byte 8 with a 32-bit
  // length in between. After a verdict, bytes are ignored until frame_start.
  // --------------------------------------------------------------------------
  function automatic res_item_t parse_byte(in_item_t it);
    res_item_t         r;
    logic              is_long;
    int                p;
    int                flag_at;
    logic [SIZE_W-1:0] need;
    logic [SIZE_W-1:0] wide_llen;
    logic [7:0]        b;

    b            = it.data_byte;
    r.status     = ST_MORE;
    r.frame_size = '0;

    if (it.frame_start) begin
      pos    = '0;
      slen   = '0;
      llen   = '0;
      judged = 1'b0;
    end

    if (!judged) begin
      p         = pos;
      is_long   = (slen == parse_cfg.long_marker);
      flag_at   = is_long ? LONG_PREFIX_BYTES : PREFIX_BYTES;
      wide_llen = SIZE_W'(llen);

      if (p == 0) begin
        if (b != parse_cfg.magic_word[7:0]) r.status = ST_BAD_MAGIC;
      end else if (p == 1) begin
        if (b != parse_cfg.magic_word[15:8]) r.status = ST_BAD_MAGIC;
      end else if (p == 2) begin
        slen = {8'h00, b};
      end else if (p == 3) begin
        slen = {b, slen[7:0]};
      end else if (p == flag_at) begin
        // flag 1 drops the message header from the minimum length
        need = SIZE_W'(FRAME_HEADER_BYTES + TRAILER_BYTES);
        if (b == 8'd0) need = need + SIZE_W'(MESSAGE_HEADER_BYTES);
        if (b > 8'd1) begin
          r.status = ST_BAD_FLAG;
        end else if (!is_long) begin
          if (SIZE_W'(slen) < need) begin
            r.status = ST_BAD_LENGTH;
          end else begin
            r.status     = ST_READY;
            r.frame_size = SIZE_W'(PREFIX_BYTES) + SIZE_W'(slen);
          end
        end else if (parse_cfg.long_body_only) begin
          r.status     = ST_READY;
          r.frame_size = SIZE_W'(LONG_PREFIX_BYTES) + need + wide_llen;
        end else if (wide_llen + SIZE_W'(TRAILER_BYTES) < need) begin
          r.status = ST_BAD_LENGTH;
        end else begin
          r.status     = ST_READY;
          r.frame_size = SIZE_W'(LONG_PREFIX_BYTES) + wide_llen + SIZE_W'(TRAILER_BYTES);
        end
      end else if (is_long && p >= 4 && p < 8) begin
        llen[(p - 4) * 8 +: 8] = b;
      end

      if (r.status != ST_MORE) judged = 1'b1;
      else if (pos != '1) pos = pos + 1'b1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: hold an item until taken, then pop the next one after a
  // random gap. Predict the verdict at the edge where the item is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_verdicts = {pending_verdicts, parse_byte(in_if.data)};
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (frame_bytes.size() != 0) begin
          in_if.data  <= frame_bytes.pop_front();
          in_if.valid <= 1'b1;
          src_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: compare each returned item with the oldest prediction,
  // then drop ready for a random gap or for the whole long stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    res_item_t want;
    res_item_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_verdicts.size() == 0) begin
          note_fault($sformatf("unexpected item: status %0d size 0x%0h",
                               got.status, got.frame_size));
        end else begin
          want = pending_verdicts.pop_front();
          if (got.status !== want.status || got.frame_size !== want.frame_size)
            note_fault($sformatf("mismatch: expected status %0d size 0x%0h, got status %0d size 0x%0h",
                                 want.status, want.frame_size, got.status, got.frame_size));
        end
        sink_gap = pick_gap();
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long output stall once traffic is flowing; the source keeps offering
  // so both pipeline stages fill and in_i.ready must drop.
  initial begin
    hold_off = 1'b0;
    wait (items_taken >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic s, input bit counts);
    in_item_t it;
    it.data_byte = b;
    it.frame_start = s;
    frame_bytes = {frame_bytes, it};
    if (counts) stim_cnt++;
  endtask

  // Queue a byte run; only the first byte may carry frame_start
  task automatic put_seq(input byte_seq_t seq, input logic s);
    foreach (seq[i]) put_byte(seq[i], (i == 0) ? s : 1'b0, 1'b1);
  endtask

  // Queue one random frame: mostly well formed, some with a corrupted magic
  // byte, some cut short, some plain noise with random start flags.
  task automatic push_frame();
    int          kind;
    int          r;
    int          idx;
    logic [7:0]  flag;
    logic [15:0] need;
    logic [15:0] len16;
    logic [31:0] len32;
    byte_seq_t   seq;

    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6))
        put_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 2) == 0), 1'b1);
      return;
    end

    flag = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255))
                                       : 8'($urandom_range(0, 1));
    need = (flag == 8'd1) ? 16'(FRAME_HEADER_BYTES + TRAILER_BYTES)
                          : 16'(FRAME_HEADER_BYTES + MESSAGE_HEADER_BYTES + TRAILER_BYTES);
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: len16 = parse_cfg.long_marker;
      3:       len16 = need - 16'd1;
      4:       len16 = need;
      5:       len16 = 16'hFFFF;
      6:       len16 = 16'($urandom_range(0, 12));
      default: len16 = 16'($urandom_range(0, 65535));
    endcase
    r = $urandom_range(0, 5);
    case (r)
      0:       len32 = '0;
      1:       len32 = 32'($urandom_range(0, 10));
      2:       len32 = 32'hFFFF_FFFF;
      default: len32 = $urandom;
    endcase

    seq = {seq, parse_cfg.magic_word[7:0]};
    seq = {seq, parse_cfg.magic_word[15:8]};
    seq = {seq, len16[7:0]};
    seq = {seq, len16[15:8]};
    if (len16 == parse_cfg.long_marker)
      for (int i = 0; i < 4; i++) seq = {seq, len32[i * 8 +: 8]};
    seq = {seq, flag};

    if (kind >= 70 && kind < 80) begin
      // corrupt one magic byte and stop there
      idx = $urandom_range(0, 1);
      seq[idx] = seq[idx] ^ 8'($urandom_range(1, 255));
      seq = seq[0:idx];
    end else if (kind >= 80) begin
      seq = seq[0:$urandom_range(0, seq.size() - 2)];
    end
    put_seq(seq, 1'b1);

    // stray bytes after a verdict are ignored by the block
    if (kind < 70 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // Wait until every queued byte is taken and every verdict has come back,
  // then allow the two-stage pipeline to settle.
  task automatic drain();
    wait (frame_bytes.size() == 0 && !in_if.valid && pending_verdicts.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_MAGIC_WORD:     parse_cfg.magic_word     = val;
      CFG_LONG_MARKER:    parse_cfg.long_marker    = val;
      CFG_LONG_BODY_ONLY: parse_cfg.long_body_only = val[0];
      default: ;
    endcase
  endtask

  // Write all registers; upper bits of the one-bit register carry junk
  task automatic set_regs(input logic [CFG_W-1:0] magic, input logic [CFG_W-1:0] marker,
                          input logic body_only);
    write_reg(CFG_MAGIC_WORD, magic);
    write_reg(CFG_LONG_MARKER, marker);
    write_reg(CFG_LONG_BODY_ONLY, {15'($urandom_range(0, 32767)), body_only});
  endtask

  task automatic random_phase();
    int quota;
    quota = stim_cnt + PHASE_ITEMS;
    while (stim_cnt < quota) push_frame();
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_MAGIC_WORD;
    cfg_wdata_i  = '0;

    parse_cfg.magic_word     = MAGIC_WORD_RST;
    parse_cfg.long_marker    = LONG_MARKER_RST;
    parse_cfg.long_body_only = LONG_BODY_RST;
    pos    = '0;
    slen   = '0;
    llen   = '0;
    judged = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under reset register values. The first frame carries
    // no frame_start: parsing after reset must begin at byte 0 regardless.
    // Shortest legal short length, then a stray byte after the verdict.
    put_seq('{MAGIC_WORD_RST[7:0], MAGIC_WORD_RST[15:8], 8'd9, 8'd0, 8'd0}, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b1);
    // Bad magic on the low byte, then on the high byte
    put_seq('{~MAGIC_WORD_RST[7:0]}, 1'b1);
    put_seq('{MAGIC_WORD_RST[7:0], ~MAGIC_WORD_RST[15:8]}, 1'b1);
    // Long prefix with the largest long length and a control flag above one
    put_seq('{MAGIC_WORD_RST[7:0], MAGIC_WORD_RST[15:8], LONG_MARKER_RST[7:0],
              LONG_MARKER_RST[15:8], 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
    // Short length one below the minimum with flag set
    put_seq('{MAGIC_WORD_RST[7:0], MAGIC_WORD_RST[15:8], 8'd4, 8'd0, 8'd1}, 1'b1);
    drain();

    // Reset values, no idling on either side
    gaps_on = 1'b0;
    random_phase();
    gaps_on = 1'b1;

    // Extremes: all-zero and all-one magic and marker, both length modes
    set_regs(16'h0000, 16'h0000, 1'b1);
    random_phase();
    set_regs(16'hFFFF, 16'hFFFF, 1'b0);
    random_phase();

    // Random settings; the marker sometimes lands near the minimum lengths
    repeat (3) begin
      set_regs(16'($urandom_range(0, 65535)),
               ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 12))
                                           : 16'($urandom_range(0, 65535)),
               1'($urandom_range(0, 1)));
      random_phase();
    end

    set_regs(MAGIC_WORD_RST, LONG_MARKER_RST, LONG_BODY_RST);
    random_phase();

    repeat (10) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
